[rtl/pmc_pkg.sv]
`timescale 1ns / 1ps
// Package for the path MTU cache: sizes, operation codes, register indexes
// and the layout of one stored entry. No dependencies.
package pmc_pkg;

    localparam int MAX_ENTRIES = 1023;
    localparam int SLOTS       = MAX_ENTRIES + 1;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int CFG_IDX_W   = 8;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_REPORT = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_MTU = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MTU     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIFETIME    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT  = 8'd3;

    typedef struct packed {
        logic [31:0] stamp;
        logic [15:0] mtu;
        logic [31:0] address;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/path_mtu_cache.sv]
`timescale 1ns / 1ps
// Top level of the path MTU cache: sequencer, registers and entry store.
// Depends on pmc_pkg and pmc_ram.
//
// Usage. Items enter on the s_ stream: tuser carries the operation (lookup,
// report, tick), tdata the destination address and reported MTU. Each item
// gives exactly one result item on the m_ stream: path MTU, hit flag and the
// number of entries a sweep removed. Registers are written on the cfg port,
// which is always ready; write them only while the block is idle.
// Entries are kept in one RAM ordered by recency, newest at position 0; the
// RAM has one write port and one registered read port. A tick goes straight
// to its result. A lookup scans from position 0 until it hits; a miss scans
// every stored entry and returns the default MTU.
// A report scans the same way. If the address is new or its MTU differs, it
// moves every newer entry one place older, then writes the front entry. An
// insert that overflows the table adds a sweep over the entries it keeps.
// The block takes one item at a time; s_tready is high only while idle.
// A result waits in the output register while m_tready is low, and the next
// item may be accepted meanwhile. Reset empties the table at once and loads
// the register defaults (default MTU 1500, minimum 68, lifetime 3600,
// keep count 512); no clearing pass is needed.
module path_mtu_cache (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // destination_address, reported_mtu
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result MTU, hit, removed count, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [pmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_SHIFT_RD, ST_SHIFT_WR,
        ST_FRONT_WR, ST_SWEEP_RD, ST_SWEEP_CMP, ST_DONE
    } state_t;

    state_t state_reg;
    logic [15:0] default_mtu_reg;
    logic [15:0] min_mtu_reg;
    logic [31:0] lifetime_reg;
    logic [9:0]  keep_count_reg;
    logic [pmc_pkg::CNT_W-1:0] total_reg;
    logic [31:0] time_reg;
    logic [pmc_pkg::CNT_W-1:0] idx_reg;
    logic [1:0]  op_reg;
    logic [31:0] addr_reg;
    logic [15:0] mtu_reg;
    logic        hit_reg;
    logic        insert_reg;
    logic [pmc_pkg::CNT_W-1:0] removed_reg;
    logic        m_tvalid_reg;
    logic [15:0] out_mtu_reg;
    logic        out_hit_reg;
    logic [pmc_pkg::CNT_W-1:0] out_removed_reg;

    logic        ram_wr_en;
    logic [pmc_pkg::IDX_W-1:0] ram_wr_addr;
    pmc_pkg::entry_t ram_wr_data;
    pmc_pkg::entry_t rd_entry;
    logic [pmc_pkg::ENTRY_W-1:0] ram_rd_data;
    logic [15:0] clamped_mtu;
    logic [31:0] age;
    logic        s_accept;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {4'd0, out_removed_reg, out_hit_reg, out_mtu_reg};
    assign rd_entry  = pmc_pkg::entry_t'(ram_rd_data);
    assign clamped_mtu = (s_tdata[47:32] < min_mtu_reg) ? min_mtu_reg : s_tdata[47:32];
    assign age = time_reg - rd_entry.stamp;

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg[pmc_pkg::IDX_W-1:0] + 1'b1;
        ram_wr_data = rd_entry;
        if (state_reg == ST_SHIFT_WR) begin
            ram_wr_en = 1'b1;
        end else if (state_reg == ST_FRONT_WR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            ram_wr_data = '{stamp: time_reg, mtu: mtu_reg, address: addr_reg};
        end
    end

    pmc_ram #(
        .WIDTH(pmc_pkg::ENTRY_W),
        .DEPTH(pmc_pkg::SLOTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (idx_reg[pmc_pkg::IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            default_mtu_reg <= 16'd1500;
            min_mtu_reg     <= 16'd68;
            lifetime_reg    <= 32'd3600;
            keep_count_reg  <= 10'd512;
            total_reg       <= '0;
            time_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    pmc_pkg::REG_DEFAULT_MTU: default_mtu_reg <= cfg_data[15:0];
                    pmc_pkg::REG_MIN_MTU:     min_mtu_reg     <= cfg_data[15:0];
                    pmc_pkg::REG_LIFETIME:    lifetime_reg    <= cfg_data;
                    pmc_pkg::REG_KEEP_COUNT:  keep_count_reg  <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        op_reg      <= s_tuser;
                        addr_reg    <= s_tdata[31:0];
                        mtu_reg     <= (s_tuser == pmc_pkg::OP_REPORT) ? clamped_mtu : '0;
                        hit_reg     <= 1'b0;
                        insert_reg  <= 1'b0;
                        removed_reg <= '0;
                        idx_reg     <= '0;
                        if (s_tuser == pmc_pkg::OP_TICK) begin
                            time_reg  <= time_reg + 32'd1;
                            state_reg <= ST_DONE;
                        end else if (s_tuser == pmc_pkg::OP_LOOKUP) begin
                            state_reg <= ST_SCAN_RD;
                        end else if (s_tuser == pmc_pkg::OP_REPORT) begin
                            state_reg <= ST_SCAN_RD;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SCAN_RD: begin
                    if (idx_reg >= total_reg) begin
                        if (op_reg == pmc_pkg::OP_LOOKUP) begin
                            mtu_reg   <= default_mtu_reg;
                            state_reg <= ST_DONE;
                        end else begin
                            insert_reg <= 1'b1;
                            if (total_reg == '0) begin
                                state_reg <= ST_FRONT_WR;
                            end else begin
                                idx_reg   <= total_reg - 1'b1;
                                state_reg <= ST_SHIFT_RD;
                            end
                        end
                    end else begin
                        state_reg <= ST_SCAN_CMP;
                    end
                end
                ST_SCAN_CMP: begin
                    if (rd_entry.address == addr_reg) begin
                        hit_reg <= 1'b1;
                        if (op_reg == pmc_pkg::OP_LOOKUP) begin
                            mtu_reg   <= rd_entry.mtu;
                            state_reg <= ST_DONE;
                        end else if (rd_entry.mtu == mtu_reg) begin
                            state_reg <= ST_DONE;
                        end else if (idx_reg == '0) begin
                            state_reg <= ST_FRONT_WR;
                        end else begin
                            idx_reg   <= idx_reg - 1'b1;
                            state_reg <= ST_SHIFT_RD;
                        end
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_SHIFT_RD: begin
                    state_reg <= ST_SHIFT_WR;
                end
                ST_SHIFT_WR: begin
                    if (idx_reg == '0) begin
                        state_reg <= ST_FRONT_WR;
                    end else begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= ST_SHIFT_RD;
                    end
                end
                ST_FRONT_WR: begin
                    idx_reg <= '0;
                    if (insert_reg) begin
                        total_reg <= total_reg + 1'b1;
                        if (total_reg + 1'b1 > pmc_pkg::CNT_W'(pmc_pkg::MAX_ENTRIES)) begin
                            state_reg <= ST_SWEEP_RD;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_SWEEP_RD: begin
                    if (idx_reg >= total_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_SWEEP_CMP;
                    end
                end
                ST_SWEEP_CMP: begin
                    if (age > lifetime_reg || idx_reg >= {1'b0, keep_count_reg}) begin
                        removed_reg <= total_reg - idx_reg;
                        total_reg   <= idx_reg;
                        if (idx_reg == '0) begin
                            mtu_reg <= default_mtu_reg;
                        end
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_SWEEP_RD;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg    <= 1'b1;
                        out_mtu_reg     <= mtu_reg;
                        out_hit_reg     <= hit_reg;
                        out_removed_reg <= removed_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> total_reg <= pmc_pkg::CNT_W'(pmc_pkg::MAX_ENTRIES))
        else $error("entry total above maximum while idle");
    a_tick_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == pmc_pkg::OP_TICK |=> time_reg == $past(time_reg) + 32'd1)
        else $error("tick did not advance time");
    a_sweep_full: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SWEEP_RD |-> total_reg == pmc_pkg::CNT_W'(pmc_pkg::SLOTS))
        else $error("sweep running without a full table");
    a_removed_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_removed_reg != '0 |-> !out_hit_reg)
        else $error("sweep reported on a hit");
`endif

endmodule

[rtl/pmc_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
